FILE: rtl/amou_pkg.sv
// Shared types and constants for the atomic memory operation unit.
// No dependencies; every other file of the block imports this package.
package amou_pkg;

	localparam int STORE_BYTES = 4096;
	localparam int ADDR_W      = 12;
	localparam int DATA_W      = 64;

	// store is split into an even and an odd bank of 16-byte rows, so any
	// access of up to 16 bytes touches one row of each bank
	localparam int ROW_BYTES = 16;
	localparam int OFS_W     = $clog2(ROW_BYTES);
	localparam int ROWSEL_W  = ADDR_W - OFS_W;
	localparam int BANK_ROWS = (STORE_BYTES + 2 * ROW_BYTES - 1) / (2 * ROW_BYTES);
	localparam int ROW_AW    = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;

	// wide enough for STORE_BYTES and for the largest address plus 16
	localparam int LIM_W = ($clog2(STORE_BYTES + 1) > ADDR_W + 1) ?
		$clog2(STORE_BYTES + 1) : ADDR_W + 1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [DATA_W-1:0] ATOMIC_COST  = 64'd400;
	localparam logic [DATA_W-1:0] BARRIER_COST = 64'd200;

	typedef enum logic [3:0] {
		K_LOAD    = 4'd0,
		K_STORE   = 4'd1,
		K_CMPXCHG = 4'd2,
		K_ADD     = 4'd3,
		K_SUB     = 4'd4,
		K_AND     = 4'd5,
		K_OR      = 4'd6,
		K_XOR     = 4'd7,
		K_BARRIER = 4'd8
	} kind_t;

	localparam logic [2:0] SZ_8   = 3'd0;
	localparam logic [2:0] SZ_16  = 3'd1;
	localparam logic [2:0] SZ_32  = 3'd2;
	localparam logic [2:0] SZ_64  = 3'd3;
	localparam logic [2:0] SZ_128 = 3'd4;

	typedef enum logic [1:0] {
		COST_NONE    = 2'd0,
		COST_ATOMIC  = 2'd1,
		COST_BARRIER = 2'd2
	} cost_t;

	typedef struct packed {
		logic [3:0]        kind;
		logic [2:0]        size_code;
		logic [ADDR_W-1:0] byte_address;
		logic [DATA_W-1:0] operand_low;
		logic [DATA_W-1:0] operand_high;
		logic [DATA_W-1:0] expected_low;
		logic [DATA_W-1:0] expected_high;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] old_low;
		logic [DATA_W-1:0] old_high;
		logic              swapped;
		logic [DATA_W-1:0] cost_count;
		logic              fault;
	} rsp_t;

	// classified item as it waits between front and back
	typedef struct packed {
		kind_t             op;
		logic [2:0]        size_code;
		logic [ADDR_W-1:0] addr;
		logic              fault;
		logic              mem_op;
		cost_t             cost_sel;
		logic [DATA_W-1:0] opl;
		logic [DATA_W-1:0] oph;
		logic [DATA_W-1:0] exl;
		logic [DATA_W-1:0] exh;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

FILE: rtl/amou_front.sv
// Front end: accepts requests and classifies them (fault, cost, memory use).
// Depends on amou_pkg.
module amou_front import amou_pkg::*; (
	input  logic         start,
	input  req_t         request,
	input  q_status_t    q_status,
	input  back_status_t bk_status,
	output logic         busy,
	output logic         push,
	output q_entry_t     entry
);

	logic [LIM_W-1:0] span_end;

	assign busy = bk_status.clearing | q_status.full;
	assign push = start & ~busy;

	assign span_end = LIM_W'(request.byte_address) + (LIM_W'(1) << request.size_code);

	always_comb begin
		entry           = '0;
		entry.op        = kind_t'(request.kind);
		entry.size_code = request.size_code;
		entry.addr      = request.byte_address;
		entry.opl       = request.operand_low;
		entry.oph       = request.operand_high;
		entry.exl       = request.expected_low;
		entry.exh       = request.expected_high;
		entry.cost_sel  = COST_NONE;
		priority if (request.kind == K_BARRIER) begin
			entry.cost_sel = COST_BARRIER;
		end else if (request.kind > K_BARRIER || request.size_code > SZ_128 ||
				(request.size_code == SZ_128 && request.kind != K_CMPXCHG)) begin
			entry.fault = 1'b1;
		end else if (span_end > LIM_W'(STORE_BYTES)) begin
			entry.fault = 1'b1;
		end else begin
			entry.mem_op = 1'b1;
			if (request.kind != K_LOAD && request.kind != K_STORE)
				entry.cost_sel = COST_ATOMIC;
		end
	end

endmodule

FILE: rtl/amou_queue.sv
// Short FIFO of classified items between front and back.
// Depends on amou_pkg.
module amou_queue import amou_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_entry,
	input  logic      pop,
	output q_entry_t  head,
	output q_status_t status
);

	q_entry_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head          = slot_q[rd_ptr_q];
	assign status.empty  = (count_q == '0);
	assign status.full   = (count_q == QCNT_W'(QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

FILE: rtl/amou_back.sv
// Back end: banked byte store, read-modify-write sequencer, cost counter.
// Depends on amou_pkg; takes items from amou_queue.
module amou_back import amou_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  q_entry_t     head,
	input  q_status_t    q_status,
	output logic         pop,
	output back_status_t status,
	output logic         done,
	output rsp_t         result
);

	typedef logic [ROW_BYTES-1:0][7:0] row_t;
	localparam int WIN_W = 2 * ROW_BYTES * 8;
	localparam int VAL_W = ROW_BYTES * 8;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t            state_q;
	logic [ROW_AW-1:0] clr_q;
	logic [DATA_W-1:0] cost_q;
	logic              done_q;
	q_entry_t          ent_q;
	rsp_t              result_q;
	row_t              rd_even_q, rd_odd_q;

	row_t mem_even [BANK_ROWS];
	row_t mem_odd  [BANK_ROWS];

	function automatic logic [ROW_AW-1:0] even_row(input logic [ADDR_W-1:0] a);
		logic [ROWSEL_W:0] r1;
		r1 = {1'b0, a[ADDR_W-1:OFS_W]} + (ROWSEL_W + 1)'(1);
		return ROW_AW'(r1 >> 1);
	endfunction

	function automatic logic [ROW_AW-1:0] odd_row(input logic [ADDR_W-1:0] a);
		return ROW_AW'(a[ADDR_W-1:OFS_W] >> 1);
	endfunction

	// read cycle: pop the head and fetch both rows it may touch
	assign pop             = (state_q == ST_IDLE) && !q_status.empty;
	assign status.clearing = (state_q == ST_CLEAR);

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_even_q <= mem_even[even_row(head.addr)];
			rd_odd_q  <= mem_odd[odd_row(head.addr)];
			ent_q     <= head;
		end
	end

	// execute cycle: align, operate, merge back
	logic [OFS_W-1:0]     ofs;
	logic                 odd_start;
	logic [WIN_W-1:0]     win, wwin;
	logic [2*ROW_BYTES-1:0] wbe;
	logic [ROW_BYTES-1:0] bmask;
	logic [VAL_W-1:0]     vmask, curv, opv, exv, newv;
	logic [DATA_W-1:0]    cost_add, cost_next;
	logic                 match, do_write;
	rsp_t                 res;

	assign ofs       = ent_q.addr[OFS_W-1:0];
	assign odd_start = ent_q.addr[OFS_W];
	assign win       = odd_start ? {rd_even_q, rd_odd_q} : {rd_odd_q, rd_even_q};

	always_comb begin
		unique case (ent_q.size_code)
			SZ_8:    bmask = ROW_BYTES'(16'h0001);
			SZ_16:   bmask = ROW_BYTES'(16'h0003);
			SZ_32:   bmask = ROW_BYTES'(16'h000f);
			SZ_64:   bmask = ROW_BYTES'(16'h00ff);
			default: bmask = '1;
		endcase
		for (int b = 0; b < ROW_BYTES; b++)
			vmask[b*8 +: 8] = {8{bmask[b]}};
	end

	assign curv  = VAL_W'(win >> {ofs, 3'b000}) & vmask;
	assign opv   = {ent_q.oph, ent_q.opl} & vmask;
	assign exv   = {ent_q.exh, ent_q.exl} & vmask;
	assign match = (curv == exv);

	always_comb begin
		newv     = opv;
		do_write = 1'b0;
		if (ent_q.mem_op && !ent_q.fault) begin
			unique case (ent_q.op)
				K_STORE:   do_write = 1'b1;
				K_CMPXCHG: do_write = match;
				K_ADD: begin
					newv     = VAL_W'(curv[DATA_W-1:0] + opv[DATA_W-1:0]) & vmask;
					do_write = 1'b1;
				end
				K_SUB: begin
					newv     = VAL_W'(curv[DATA_W-1:0] - opv[DATA_W-1:0]) & vmask;
					do_write = 1'b1;
				end
				K_AND: begin
					newv     = curv & opv;
					do_write = 1'b1;
				end
				K_OR: begin
					newv     = curv | opv;
					do_write = 1'b1;
				end
				K_XOR: begin
					newv     = curv ^ opv;
					do_write = 1'b1;
				end
				default: do_write = 1'b0;
			endcase
		end
	end

	assign wwin = WIN_W'(newv) << {ofs, 3'b000};
	assign wbe  = (do_write && state_q == ST_EXEC) ?
		((2 * ROW_BYTES)'(bmask) << ofs) : '0;

	always_comb begin
		unique case (ent_q.cost_sel)
			COST_ATOMIC:  cost_add = ATOMIC_COST;
			COST_BARRIER: cost_add = BARRIER_COST;
			default:      cost_add = '0;
		endcase
	end
	assign cost_next = cost_q + cost_add;

	always_comb begin
		res            = '0;
		res.cost_count = cost_next;
		res.fault      = ent_q.fault;
		if (ent_q.mem_op && !ent_q.fault && ent_q.op != K_STORE) begin
			res.old_low  = curv[DATA_W-1:0];
			res.old_high = curv[VAL_W-1:DATA_W];
			res.swapped  = (ent_q.op == K_CMPXCHG) && match;
		end
	end

	// bank write ports: clearing pass or the merged rows of the execute cycle
	logic [ROW_AW-1:0]    w_idx_e, w_idx_o;
	logic [ROW_BYTES-1:0] w_be_e, w_be_o;
	row_t                 w_d_e, w_d_o;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			w_idx_e = clr_q;
			w_idx_o = clr_q;
			w_be_e  = '1;
			w_be_o  = '1;
			w_d_e   = '0;
			w_d_o   = '0;
		end else begin
			w_idx_e = even_row(ent_q.addr);
			w_idx_o = odd_row(ent_q.addr);
			if (odd_start) begin
				w_d_o  = wwin[VAL_W-1:0];
				w_be_o = wbe[ROW_BYTES-1:0];
				w_d_e  = wwin[WIN_W-1:VAL_W];
				w_be_e = wbe[2*ROW_BYTES-1:ROW_BYTES];
			end else begin
				w_d_e  = wwin[VAL_W-1:0];
				w_be_e = wbe[ROW_BYTES-1:0];
				w_d_o  = wwin[WIN_W-1:VAL_W];
				w_be_o = wbe[2*ROW_BYTES-1:ROW_BYTES];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (|w_be_e) begin
			for (int b = 0; b < ROW_BYTES; b++)
				if (w_be_e[b])
					mem_even[w_idx_e][b] <= w_d_e[b];
		end
		if (|w_be_o) begin
			for (int b = 0; b < ROW_BYTES; b++)
				if (w_be_o[b])
					mem_odd[w_idx_o][b] <= w_d_o[b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cost_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ROW_AW'(BANK_ROWS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					cost_q  <= cost_next;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC)
			result_q <= res;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: rtl/atomic_memory_op_unit_top.sv
// Top level of the atomic memory operation unit: front, queue and back.
// Depends on amou_pkg, amou_front, amou_queue and amou_back.

// A request is taken at a clock edge where start is high and busy is low.
// Each request gives one result, shown on result for exactly one cycle with
// done high; the receiver cannot stall it, so it must be taken then.
// The back end handles each request in a read cycle of the two-bank row
// store, then an operate-and-write cycle, and takes no new request until it
// is through with the last; a two-entry queue lets the front accept while
// the back is working. After reset the store is cleared one row pair per
// cycle, and busy stays high until every row pair has been cleared.
module atomic_memory_op_unit_top import amou_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output logic done,
	output rsp_t result
);

	logic         push, pop;
	q_entry_t     entry, head;
	q_status_t    q_status;
	back_status_t bk_status;

	amou_front u_front (
		.start     (start),
		.request   (request),
		.q_status  (q_status),
		.bk_status (bk_status),
		.busy      (busy),
		.push      (push),
		.entry     (entry)
	);

	amou_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	amou_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.status   (bk_status),
		.done     (done),
		.result   (result)
	);

	// back end never issues results in consecutive cycles
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results issued back to back");

	// queue must never be pushed while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("queue overflow");

	// a faulted request reports no swap and no old data
	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.fault |-> !result.swapped && result.old_low == '0 &&
			result.old_high == '0)
		else $error("faulted request carries data");

	// nothing enters the queue or reaches the back end during the clearing pass
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.clearing |-> !pop && !push)
		else $error("item moved during store clear");

endmodule

FILE: bench/atomic_memory_op_unit_top_tb.sv
// Self-checking bench for atomic_memory_op_unit_top: directed and random items, checked
// against a behavioral mirror of the byte store and the cost counter.
// Depends on amou_pkg and the RTL of the block.
module atomic_memory_op_unit_top_tb import amou_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;

	atomic_memory_op_unit_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	always #2 clk = ~clk;

	// mirror of the block's architectural state
	logic [7:0]  mirror_mem [STORE_BYTES];
	logic [63:0] mirror_cost;

	rsp_t due_responses [$];
	int mismatches = 0;
	int items_sent = 0;
	int faults_seen = 0;
	int swaps_seen = 0;
	int responses_seen = 0;
	int burst_left = 0;

	function automatic logic [63:0] mem_read(int a, int n);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < n; i++)
			v |= 64'(mirror_mem[(a + i) % STORE_BYTES]) << (8 * i);
		return v;
	endfunction

	function automatic void mem_write(int a, int n, logic [63:0] v);
		for (int i = 0; i < n; i++)
			mirror_mem[(a + i) % STORE_BYTES] = v[8*i +: 8];
	endfunction

	// next state of the mirror and the response the block owes for one item
	function automatic rsp_t apply_atomic(req_t r);
		rsp_t o;
		logic [63:0] mask, cur, opnd;
		int nb, a;
		o = '0;
		a = int'(r.byte_address);
		nb = 1 << r.size_code;
		if (r.kind == K_BARRIER) begin
			mirror_cost += BARRIER_COST;
		end else if (r.kind > K_BARRIER || r.size_code > SZ_128 ||
				(r.size_code == SZ_128 && r.kind != K_CMPXCHG)) begin
			o.fault = 1'b1;
		end else if (a + nb > STORE_BYTES) begin
			o.fault = 1'b1;
		end else if (r.size_code == SZ_128) begin
			mirror_cost += ATOMIC_COST;
			o.old_low = mem_read(a, 8);
			o.old_high = mem_read(a + 8, 8);
			if (o.old_low == r.expected_low && o.old_high == r.expected_high) begin
				mem_write(a, 8, r.operand_low);
				mem_write(a + 8, 8, r.operand_high);
				o.swapped = 1'b1;
			end
		end else begin
			mask = (r.size_code == SZ_64) ? '1 : (64'd1 << (8 * nb)) - 64'd1;
			opnd = r.operand_low & mask;
			if (r.kind == K_STORE) begin
				mem_write(a, nb, opnd);
			end else begin
				cur = mem_read(a, nb);
				o.old_low = cur;
				if (r.kind != K_LOAD)
					mirror_cost += ATOMIC_COST;
				case (r.kind)
					K_CMPXCHG: begin
						if (cur == (r.expected_low & mask)) begin
							mem_write(a, nb, opnd);
							o.swapped = 1'b1;
						end
					end
					K_ADD: mem_write(a, nb, cur + opnd);
					K_SUB: mem_write(a, nb, cur - opnd);
					K_AND: mem_write(a, nb, cur & opnd);
					K_OR:  mem_write(a, nb, cur | opnd);
					K_XOR: mem_write(a, nb, cur ^ opnd);
					default: ;
				endcase
			end
		end
		o.cost_count = mirror_cost;
		return o;
	endfunction

	function automatic req_t mk(logic [3:0] kind, logic [2:0] sc, int addr,
			logic [63:0] opl, logic [63:0] oph, logic [63:0] exl, logic [63:0] exh);
		req_t r;
		r.kind = kind;
		r.size_code = sc;
		r.byte_address = ADDR_W'(addr);
		r.operand_low = opl;
		r.operand_high = oph;
		r.expected_low = exl;
		r.expected_high = exh;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic send_item(input req_t r);
		rsp_t want;
		request <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		want = apply_atomic(r);
		due_responses.push_back(want);
		items_sent++;
		if (want.fault) faults_seen++;
		if (want.swapped) swaps_seen++;
	endtask

	// mostly short gaps, a few long ones, and now and then a back-to-back run
	task automatic pause_between();
		int n, roll;
		roll = $urandom_range(99, 0);
		n = 0;
		if (burst_left > 0)
			burst_left--;
		else if (roll < 5)
			burst_left = $urandom_range(30, 10);
		else if (roll < 50)
			n = 0;
		else if (roll < 90)
			n = $urandom_range(3, 1);
		else
			n = $urandom_range(40, 8);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic issue(input req_t r);
		send_item(r);
		pause_between();
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			responses_seen++;
			if (due_responses.size() == 0) begin
				$error("response with no item outstanding");
				mismatches++;
			end else begin
				want = due_responses.pop_front();
				check_field("old_low", want.old_low, result.old_low);
				check_field("old_high", want.old_high, result.old_high);
				check_field("swapped", 64'(want.swapped), 64'(result.swapped));
				check_field("cost_count", want.cost_count, result.cost_count);
				check_field("fault", 64'(want.fault), 64'(result.fault));
			end
		end
	end

	task automatic test_plain_access();
		issue(mk(K_LOAD, SZ_8, 0, '1, '1, '1, '1));
		issue(mk(K_STORE, SZ_64, 0, 64'h8877_6655_4433_2211, '1, '1, '1));
		issue(mk(K_LOAD, SZ_8, 3, 0, 0, 0, 0));
		issue(mk(K_LOAD, SZ_16, 1, 0, 0, 0, 0));
		issue(mk(K_LOAD, SZ_32, 0, 0, 0, 0, 0));
		issue(mk(K_LOAD, SZ_64, 0, 0, 0, 0, 0));
		// upper operand bits must be dropped on a narrow store
		issue(mk(K_STORE, SZ_8, STORE_BYTES - 1, 64'hFFFF_FFFF_FFFF_FFAB, 0, 0, 0));
		issue(mk(K_LOAD, SZ_8, STORE_BYTES - 1, 0, 0, 0, 0));
	endtask

	task automatic test_fetch_ops();
		issue(mk(K_ADD, SZ_32, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
		issue(mk(K_SUB, SZ_16, 8, 64'd1, 0, 0, 0));
		issue(mk(K_AND, SZ_64, 0, 64'hF0F0_F0F0_0FF0_FF00, 0, 0, 0));
		issue(mk(K_OR, SZ_8, 2, 64'h1234_5678_9ABC_DE81, 0, 0, 0));
		issue(mk(K_XOR, SZ_64, 0, '1, 0, 0, 0));
	endtask

	task automatic test_compare_exchange();
		// narrow match with noise above the access width in the expected value
		issue(mk(K_CMPXCHG, SZ_8, 8, 64'h5A, 0, {56'hABCDEF_0123_4567, 8'(mem_read(8, 1))}, 0));
		issue(mk(K_CMPXCHG, SZ_64, 0, 64'h1, 0, ~mem_read(0, 8), 0));
		issue(mk(K_CMPXCHG, SZ_128, STORE_BYTES - 16, rand64(), rand64(), 0, 0));
		issue(mk(K_CMPXCHG, SZ_128, STORE_BYTES - 16, '1, '1,
			mem_read(STORE_BYTES - 16, 8), ~mem_read(STORE_BYTES - 8, 8)));
		issue(mk(K_CMPXCHG, SZ_128, 0, rand64(), rand64(), mem_read(0, 8), mem_read(8, 8)));
	endtask

	task automatic test_faults_and_barrier();
		issue(mk(4'hF, SZ_8, 0, '1, '1, '1, '1));
		issue(mk(4'(K_BARRIER) + 4'd1, SZ_32, 16, '1, 0, 0, 0));
		issue(mk(K_LOAD, 3'd7, 0, 0, 0, 0, 0));
		issue(mk(K_STORE, 3'd5, 0, '1, 0, 0, 0));
		issue(mk(K_ADD, SZ_128, 0, 1, 0, 0, 0));
		issue(mk(K_LOAD, SZ_128, 0, 0, 0, 0, 0));
		issue(mk(K_STORE, SZ_64, STORE_BYTES - 8, rand64(), 0, 0, 0));
		issue(mk(K_ADD, SZ_64, STORE_BYTES - 7, 1, 0, 0, 0));
		issue(mk(K_CMPXCHG, SZ_128, STORE_BYTES - 15, 0, 0, 0, 0));
		issue(mk(K_XOR, SZ_16, STORE_BYTES - 1, '1, 0, 0, 0));
		// size and address are don't-care for a barrier
		issue(mk(K_BARRIER, 3'd7, STORE_BYTES - 1, '1, '1, '1, '1));
	endtask

	function automatic req_t random_request();
		req_t r;
		int roll, a, nb;
		logic [63:0] mask, cur;
		roll = $urandom_range(99, 0);
		r = mk(K_LOAD, SZ_8, 0, rand64(), rand64(), rand64(), rand64());
		if (roll < 8) begin
			r.kind = 4'(K_BARRIER) + 4'($urandom_range(7, 1));
			r.size_code = 3'($urandom_range(7, 0));
		end else if (roll < 14) begin
			r.kind = K_BARRIER;
			r.size_code = 3'($urandom_range(7, 0));
		end else if (roll < 24) begin
			r.kind = K_LOAD;
		end else if (roll < 36) begin
			r.kind = K_STORE;
		end else if (roll < 58) begin
			r.kind = K_CMPXCHG;
		end else begin
			r.kind = 4'(K_ADD) + 4'($urandom_range(4, 0));
		end
		if (r.kind <= K_XOR) begin
			roll = $urandom_range(99, 0);
			if (roll < 4)
				r.size_code = 3'($urandom_range(7, 5));
			else if (roll < 7 || (r.kind == K_CMPXCHG && roll < 30))
				r.size_code = SZ_128;
			else
				r.size_code = 3'($urandom_range(3, 0));
		end
		roll = $urandom_range(99, 0);
		if (roll < 70)
			a = $urandom_range(63, 0);
		else if (roll < 85)
			a = $urandom_range(STORE_BYTES - 1, STORE_BYTES - 20);
		else
			a = $urandom_range(STORE_BYTES - 1, 0);
		r.byte_address = ADDR_W'(a);
		roll = $urandom_range(99, 0);
		if (roll < 30)
			r.operand_low = 64'($urandom_range(3, 0));
		else if (roll < 45)
			r.operand_low = '1;
		if (r.kind == K_CMPXCHG && $urandom_range(99, 0) < 65) begin
			if (r.size_code == SZ_128) begin
				r.expected_low = mem_read(a, 8);
				r.expected_high = mem_read(a + 8, 8);
				// a miss on the high half alone
				if ($urandom_range(9, 0) == 0)
					r.expected_high[$urandom_range(63, 0)] ^= 1'b1;
			end else if (r.size_code <= SZ_64) begin
				nb = 1 << r.size_code;
				mask = (r.size_code == SZ_64) ? '1 : (64'd1 << (8 * nb)) - 64'd1;
				cur = mem_read(a, nb);
				r.expected_low = cur ^ (rand64() & ~mask);
			end
		end
		return r;
	endfunction

	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++)
			issue(random_request());
	endtask

	initial begin
		mirror_cost = '0;
		for (int i = 0; i < STORE_BYTES; i++)
			mirror_mem[i] = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_access();
		test_fetch_ops();
		test_compare_exchange();
		test_faults_and_barrier();
		test_random_mix(400);

		start <= 1'b0;
		for (int w = 0; w < 2000 && due_responses.size() != 0; w++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (due_responses.size() != 0) begin
			$error("%0d items never answered", due_responses.size());
			mismatches++;
		end
		$display("Sent %0d items (%0d faulting, %0d swapping); %0d responses checked.",
			items_sent, faults_seen, swaps_seen, responses_seen);
		$display("Covered loads, stores, fetch-ops, 8..128-bit compare-exchange and barriers.");
		if (mismatches == 0)
			$display("atomic_memory_op_unit_top_tb: PASS");
		else
			$display("atomic_memory_op_unit_top_tb: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d items outstanding.", due_responses.size());
		$display("atomic_memory_op_unit_top_tb: FAIL");
		$finish;
	end

endmodule

FILE: atomic_memory_op_unit_top.f
rtl/amou_pkg.sv
rtl/amou_front.sv
rtl/amou_queue.sv
rtl/amou_back.sv
rtl/atomic_memory_op_unit_top.sv
bench/atomic_memory_op_unit_top_tb.sv
